// ===== hdl/ets_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

  localparam int TABLE_SIZE = 131072;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int IDX_W      = 17;
  localparam int LAST_ADDR  = TABLE_SIZE - 1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  init_we;
    addr_t init_addr;
    logic  upd_en;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/ets_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ets_table (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ets_pkg::mem_req_t req,
  output ets_pkg::addr_t        rdata_a
);

  ets_pkg::addr_t mem [ets_pkg::TABLE_SIZE];
  ets_pkg::addr_t rdata_b;
  logic           upd_v;
  ets_pkg::addr_t upd_addr;

  logic           wr_en;
  ets_pkg::addr_t wr_addr;
  ets_pkg::addr_t wr_data;

  always_comb begin
    wr_en   = req.init_we | upd_v;
    wr_addr = req.init_we ? req.init_addr : upd_addr;
    wr_data = req.init_we ? req.init_addr : ets_pkg::addr_t'(rdata_a - rdata_b);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a <= mem[req.rd_addr_a];
    rdata_b <= mem[req.rd_addr_b];
  end

  // hold the entry address for the write-back in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_v <= 1'b0;
    end else begin
      upd_v <= req.upd_en;
    end
    upd_addr <= req.rd_addr_a;
  end

endmodule

`default_nettype wire

// ===== hdl/euler_totient_sieve_table.sv =====
// Euler totient lookup table.
// After reset the block builds phi(n) for every n below the table size in
// one synchronous memory, then answers lookups from it.
// Input channel: index is taken at a rising edge where start is high and
// busy is low; that is one transfer.
// Output channel: valid is high for exactly one cycle, the cycle after the
// transfer, with totient on the port in that cycle. Indexes at or above the
// table size return zero. The receiver cannot stall; results are never held.
// Throughput: one lookup per cycle once busy is low, with the result taken
// from the single registered read of the table memory.
// Reset: rst (synchronous) restarts the build. busy stays high during the
// build: one write per entry to seed each entry with its own index, then
// for each candidate n a read and a compare, and for each prime p a forward
// count to the last multiple, then a descending read-modify-write pass that
// subtracts the cofactor's entry. Once busy falls it stays low until the
// next reset.
`timescale 1ns / 1ps
`default_nettype none

module euler_totient_sieve_table (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [ets_pkg::IDX_W-1:0] index,
  output logic                         valid,
  output logic [ets_pkg::IDX_W-1:0]    totient
);

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_CHK_RD  = 3'd1;
  localparam logic [2:0] ST_CHK_CMP = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_UPD     = 3'd4;
  localparam logic [2:0] ST_NEXT    = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  localparam ets_pkg::addr_t LAST = ets_pkg::addr_t'(ets_pkg::LAST_ADDR);
  localparam ets_pkg::addr_t ONE  = ets_pkg::addr_t'(1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  ets_pkg::addr_t    i;
  ets_pkg::addr_t    i_next;
  ets_pkg::addr_t    j;
  ets_pkg::addr_t    j_next;
  ets_pkg::addr_t    k;
  ets_pkg::addr_t    k_next;
  logic              in_range;
  logic              in_range_q;
  logic [ets_pkg::ADDR_W:0] step_sum;

  ets_pkg::mem_req_t req;
  ets_pkg::addr_t    rdata_a;

  ets_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rdata_a (rdata_a)
  );

  assign busy     = (state != ST_DONE);
  assign in_range = 32'(index) < 32'(ets_pkg::TABLE_SIZE);
  assign step_sum = (ets_pkg::ADDR_W+1)'(j) + (ets_pkg::ADDR_W+1)'(i);

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    req.rd_addr_a = j;
    req.rd_addr_b = k;
    req.init_we   = 1'b0;
    req.init_addr = j;
    req.upd_en    = 1'b0;
    case (state)
      ST_INIT: begin
        req.init_we = 1'b1;
        if (j == LAST) begin
          j_next = '0;
          i_next = ets_pkg::addr_t'(2);
          if (ets_pkg::TABLE_SIZE > 2) begin
            state_next = ST_CHK_RD;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          j_next = j + ONE;
        end
      end
      ST_CHK_RD: begin
        req.rd_addr_a = i;
        state_next    = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (rdata_a == i) begin
          j_next     = i;
          k_next     = ONE;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_SCAN: begin
        if (step_sum < (ets_pkg::ADDR_W+1)'(ets_pkg::TABLE_SIZE)) begin
          j_next = ets_pkg::addr_t'(step_sum);
          k_next = k + ONE;
        end else begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        req.upd_en = 1'b1;
        if (k == ONE) begin
          state_next = ST_NEXT;
        end else begin
          j_next = j - i;
          k_next = k - ONE;
        end
      end
      ST_NEXT: begin
        if (i == LAST) begin
          state_next = ST_DONE;
        end else begin
          i_next     = i + ONE;
          state_next = ST_CHK_RD;
        end
      end
      ST_DONE: begin
        req.rd_addr_a = ets_pkg::addr_t'(index);
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      j     <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      valid <= start & ~busy;
    end
    i          <= i_next;
    k          <= k_next;
    in_range_q <= in_range;
  end

  assign totient = in_range_q ? ets_pkg::IDX_W'(rdata_a) : '0;

  a_result_follows_transfer: assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |=> valid
  ) else $error("lookup transfer produced no result");

  a_result_has_transfer: assert property (
    @(posedge clk) disable iff (rst) valid |-> $past(start && !busy)
  ) else $error("result without a lookup transfer");

  a_ready_stays: assert property (
    @(posedge clk) disable iff (rst) !busy |=> !busy
  ) else $error("table rebuilt without reset");

  a_cofactor_nonzero: assert property (
    @(posedge clk) disable iff (rst) (state == ST_UPD) |-> (k != '0)
  ) else $error("sieve cofactor counter wrapped");

endmodule

`default_nettype wire

// ===== tb/tb_euler_totient_sieve_table.sv =====
`timescale 1ns / 1ps

class totient_scoreboard;

  localparam int TBL_N   = ets_pkg::TABLE_SIZE;

  int unsigned                     phi_by_index [TBL_N];
  logic [ets_pkg::IDX_W-1:0]       pending_totients [$];
  int                              error_count;
  int                              checked_count;

  function new();
    error_count   = 0;
    checked_count = 0;
    build_phi();
  endfunction

  // sieve: each prime p removes 1/p of every multiple's running count
  function void build_phi();
    int unsigned p;
    int unsigned m;
    phi_by_index[0] = 0;
    for (p = 1; p < TBL_N; p++) phi_by_index[p] = p;
    for (p = 2; p < TBL_N; p++) begin
      if (phi_by_index[p] == p) begin
        for (m = p; m < TBL_N; m += p) phi_by_index[m] -= phi_by_index[m] / p;
      end
    end
  endfunction

  function void record_lookup(logic [ets_pkg::IDX_W-1:0] idx);
    int unsigned phi_val;
    phi_val = 0;
    if (int'(idx) < TBL_N) phi_val = phi_by_index[idx];
    pending_totients.push_back(phi_val[ets_pkg::IDX_W-1:0]);
  endfunction

  function void check_totient(logic [ets_pkg::IDX_W-1:0] got);
    logic [ets_pkg::IDX_W-1:0] want;
    if (pending_totients.size() == 0) begin
      $error("totient: unexpected result, actual %0d", got);
      error_count++;
      return;
    end
    want = pending_totients.pop_front();
    checked_count++;
    if (got !== want) begin
      $error("totient mismatch: expected %0d, actual %0d", want, got);
      error_count++;
    end
  endfunction

  function int pending_count();
    return pending_totients.size();
  endfunction

endclass

module tb_euler_totient_sieve_table;

  localparam int IDX_W        = ets_pkg::IDX_W;
  localparam int STALL_LIMIT  = 4000000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_ITEMS  = 300;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [IDX_W-1:0]  index;
  logic              valid;
  logic [IDX_W-1:0]  totient;

  totient_scoreboard sb;
  int                lookup_count;
  int                stall_cycles;

  euler_totient_sieve_table u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .index   (index),
    .valid   (valid),
    .totient (totient)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (start && !busy) begin
        sb.record_lookup(index);
        lookup_count++;
      end
      if (valid) sb.check_totient(totient);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] idx);
    @(negedge clk);
    start <= 1'b1;
    index <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      index <= IDX_W'($urandom_range(0, IDX_MAX));
    end
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0, 1:    return IDX_W'($urandom_range(0, 255));
      2:       return IDX_W'($urandom_range(IDX_MAX - 255, IDX_MAX));
      default: return IDX_W'($urandom_range(0, IDX_MAX));
    endcase
  endfunction

  initial begin
    int k;
    int unsigned spot_checks [7];
    sb           = new();
    lookup_count = 0;
    stall_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    index        = '0;
    spot_checks  = '{0, 3, 6, 30, 65537, IDX_MAX - 1, IDX_MAX};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, all ones, primes, composites, one bit at a time
    foreach (spot_checks[s]) send_index(IDX_W'(spot_checks[s]));
    for (k = 0; k < IDX_W; k++) send_index(IDX_W'(1) << k);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k >= QUIET_ITEMS) begin
        while ($urandom_range(0, 99) < 18) idle_cycles(1);
      end
      send_index(pick_index());
    end
    idle_cycles(1);

    while (sb.pending_count() > 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Issued %0d lookups after the sieve build: directed edge indexes and random",
             lookup_count);
    $display("indexes over the full range, %0d totients compared", sb.checked_count);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
